@@ rtl/asz_pkg.sv @@
// Shared widths, register indexes and reset values for the altimeter settle-and-zero block.
package asz_pkg;

  localparam int SAMPLE_W = 20;  // Q16.4 altitude sample
  localparam int SUM_W    = 28;  // baseline accumulator
  localparam int ALT_W    = 22;  // signed result altitude
  localparam int PHASE_W  = 2;
  localparam int COUNT_W  = 4;

  localparam int TOL_W    = 10;
  localparam int REQ_W    = 4;
  localparam int OFFSET_W = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

  localparam logic [TOL_W-1:0]           RST_RANGE_TOL = 10'd32;
  localparam logic [REQ_W-1:0]           RST_REQ_WIN   = 4'd3;
  localparam logic signed [OFFSET_W-1:0] RST_OFFSET    = -9'sd16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

endpackage

@@ rtl/altimeter_settle_and_zero.sv @@
// Altimeter settle-and-zero: settling detector, baseline averager and zero-offset output stage.
//
// Each accepted beat carries one altimeter reading as three register bytes, packed into a
// Q16.4 sample in 1/16 m. The block takes one beat per clock cycle while the result side
// keeps up; an accepted beat lands in the input register, and its result is then loaded into
// the result register that drives the output, unless the result side stalls. The
// sustained rate is set by the single pass through the update logic between these two
// registers: window min/max tracking, the range check, the baseline accumulator and, on the
// last baseline sample, a divide by WINDOW done as one multiply by a constant reciprocal.
// While acclimating, samples are cut into windows of
// WINDOW samples; a window is good when its range is nonzero and below range_tolerance, a bad
// window clears the good-window count. Once required_windows good windows are seen, the next
// WINDOW samples are averaged (truncated) into the surface level, and every later result is
// |sample - surface| + output_offset. Until then the raw sample is passed through. Config
// writes are always accepted and must only happen while no beats are in flight.
module altimeter_settle_and_zero
  import asz_pkg::*;
#(
  parameter int WINDOW = 30
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_sample_msb,
  input  logic [7:0]                  in_sample_csb,
  input  logic [7:0]                  in_sample_lsb,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ALT_W-1:0]     out_altitude,
  output logic [PHASE_W-1:0]          out_phase,
  output logic [COUNT_W-1:0]          out_good_windows,
  // configuration port
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [PHASE_W-1:0] {
    PH_ACCLIM   = 2'd0,
    PH_BASELINE = 2'd1,
    PH_CAL      = 2'd2
  } phase_t;

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  // floor(x / WINDOW) = (x * DIV_M) >> DIV_S for every x below 2**SUM_W
  localparam int DIV_S    = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W  = SUM_W + 2;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] DIV_M = DIV_M64[RECIP_W-1:0];

  // configuration
  logic [TOL_W-1:0]           range_tol_r;
  logic [REQ_W-1:0]           req_win_r;
  logic signed [OFFSET_W-1:0] offset_r;

  // input register
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  // block state
  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SAMPLE_W-1:0] win_min_r, win_min_nxt;
  logic [SAMPLE_W-1:0] win_max_r, win_max_nxt;
  logic [COUNT_W-1:0]  good_cnt_r, good_cnt_nxt;
  logic [SUM_W-1:0]    base_sum_r, base_sum_nxt;
  logic [SAMPLE_W-1:0] surface_r, surface_nxt;

  // result register
  logic                       out_valid_r;
  logic signed [ALT_W-1:0]    out_alt_r, out_alt_nxt;
  logic [PHASE_W-1:0]         out_phase_r;
  logic [COUNT_W-1:0]         out_good_r;

  logic in_take;
  logic advance;

  logic                    last;
  logic [SAMPLE_W-1:0]     cur_min;
  logic [SAMPLE_W-1:0]     cur_max;
  logic [SAMPLE_W-1:0]     win_range;
  logic                    win_good;
  logic [PROD_W-1:0]       div_prod;
  logic [PROD_W-1:0]       div_quot;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0]     mag;

  // move a beat into the result register when it is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  assign last      = (idx_r == IDX_LAST);
  assign cur_min   = (s1_sample_r < win_min_r) ? s1_sample_r : win_min_r;
  assign cur_max   = (s1_sample_r > win_max_r) ? s1_sample_r : win_max_r;
  assign win_range = cur_max - cur_min;
  assign win_good  = (win_range != '0) && (win_range < SAMPLE_W'(range_tol_r));

  assign div_prod = PROD_W'(base_sum_nxt) * PROD_W'(DIV_M);
  assign div_quot = div_prod >> DIV_S;

  assign diff = $signed({1'b0, s1_sample_r}) - $signed({1'b0, surface_r});
  assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    win_min_nxt  = win_min_r;
    win_max_nxt  = win_max_r;
    good_cnt_nxt = good_cnt_r;
    base_sum_nxt = base_sum_r;
    surface_nxt  = surface_r;
    out_alt_nxt  = $signed({2'b00, s1_sample_r});

    case (phase_r)
      PH_ACCLIM: begin
        win_min_nxt = cur_min;
        win_max_nxt = cur_max;
        if (last) begin
          if (win_good) begin
            good_cnt_nxt = (good_cnt_r == COUNT_MAX) ? good_cnt_r : good_cnt_r + 1'b1;
          end else begin
            good_cnt_nxt = '0;
          end
          win_min_nxt = '1;
          win_max_nxt = '0;
          idx_nxt     = '0;
          if (good_cnt_nxt >= COUNT_W'(req_win_r)) begin
            phase_nxt    = PH_BASELINE;
            base_sum_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      PH_BASELINE: begin
        base_sum_nxt = base_sum_r + SUM_W'(s1_sample_r);
        if (last) begin
          surface_nxt = div_quot[SAMPLE_W-1:0];
          phase_nxt   = PH_CAL;
          idx_nxt     = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        out_alt_nxt = $signed({2'b00, mag})
                    + $signed({{(ALT_W-OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_tol_r <= RST_RANGE_TOL;
      req_win_r   <= RST_REQ_WIN;
      offset_r    <= RST_OFFSET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_ACCLIM;
      idx_r       <= '0;
      win_min_r   <= '1;
      win_max_r   <= '0;
      good_cnt_r  <= '0;
      base_sum_r  <= '0;
      surface_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RANGE_TOL: range_tol_r <= cfg_data[TOL_W-1:0];
          CFG_REQ_WIN:   req_win_r   <= cfg_data[REQ_W-1:0];
          CFG_OFFSET:    offset_r    <= $signed(cfg_data[OFFSET_W-1:0]);
          default:       ;
        endcase
      end

      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        idx_r       <= idx_nxt;
        win_min_r   <= win_min_nxt;
        win_max_r   <= win_max_nxt;
        good_cnt_r  <= good_cnt_nxt;
        base_sum_r  <= base_sum_nxt;
        surface_r   <= surface_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= {in_sample_msb, in_sample_csb, in_sample_lsb[7:4]};
    end
    if (advance) begin
      out_alt_r   <= out_alt_nxt;
      out_phase_r <= phase_nxt;
      out_good_r  <= good_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_altitude     = out_alt_r;
  assign out_phase        = out_phase_r;
  assign out_good_windows = out_good_r;

endmodule
